[hdl/flog2_pkg.sv]
// types and constants shared by the fixed-point log2 block
// no dependencies
`default_nettype none

package flog2_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int PREC_WIDTH = 5;
   localparam int STATUS_WIDTH = 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [PREC_WIDTH-1:0] FRACTION_BITS_RESET = 5'd16;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_BAD_PRECISION = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_ZERO_INPUT = 2'd2;

   localparam logic [DATA_WIDTH-1:0] RESULT_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_WIDTH-1:0] RESULT_MIN = 32'h8000_0000;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic [PREC_WIDTH-1:0]   prec;
      logic [DATA_WIDTH-1:0]   mantissa;
      logic [DATA_WIDTH-1:0]   int_part;
   } flog2_entry_type;

endpackage

`default_nettype wire

[hdl/flog2_front.sv]
// front end: classifies a beat, normalises the operand by leading-one position
// depends on flog2_pkg
`default_nettype none

module flog2_front
   import flog2_pkg::*;
#(
   parameter int MAX_FRACTION_BITS = 31
) (
   input  wire logic [DATA_WIDTH-1:0] operand,
   input  wire logic [PREC_WIDTH-1:0] fraction_bits,
   output flog2_entry_type            entry
);

   logic [PREC_WIDTH-1:0] msb;
   logic                  bad_prec;
   logic                  is_zero;
   logic signed [PREC_WIDTH+1:0] shift_amt;
   logic [DATA_WIDTH-1:0] shift_ext;
   logic [DATA_WIDTH-1:0] norm_mask;
   logic [DATA_WIDTH-1:0] aligned;

   always_comb begin
      msb = '0;
      for (int i = 0; i < DATA_WIDTH; i++) begin
         if (operand[i]) begin
            msb = PREC_WIDTH'(i);
         end
      end
   end

   assign bad_prec = (fraction_bits == '0) ||
                     (32'(fraction_bits) > 32'(MAX_FRACTION_BITS));
   assign is_zero  = (operand == '0);

   // integer part is msb - p, scaled by 2^p and wrapped
   assign shift_amt = $signed({2'b00, msb}) - $signed({2'b00, fraction_bits});
   assign shift_ext = {{(DATA_WIDTH-PREC_WIDTH-2){shift_amt[PREC_WIDTH+1]}}, shift_amt};

   // left-aligned mantissa, low bits below the fraction width dropped
   assign norm_mask = {DATA_WIDTH{1'b1}} << (5'd31 - fraction_bits);
   assign aligned   = (operand << (5'd31 - msb)) & norm_mask;

   always_comb begin
      entry.status   = STATUS_OK;
      entry.prec     = fraction_bits;
      entry.mantissa = aligned;
      entry.int_part = shift_ext << fraction_bits;
      if (bad_prec) begin
         entry.status   = STATUS_BAD_PRECISION;
         entry.prec     = '0;
         entry.mantissa = '0;
         entry.int_part = RESULT_MAX;
      end else if (is_zero) begin
         entry.status   = STATUS_ZERO_INPUT;
         entry.prec     = '0;
         entry.mantissa = '0;
         entry.int_part = RESULT_MIN;
      end
   end

endmodule

`default_nettype wire

[hdl/flog2_queue.sv]
// short fifo between front end and squaring engine
// depends on flog2_pkg
`default_nettype none

module flog2_queue
   import flog2_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire flog2_entry_type push_entry,
   output logic           full,
   input  wire logic      pop,
   output logic           not_empty,
   output flog2_entry_type pop_entry
);

   flog2_entry_type entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff, count_in;

   assign full      = (count_ff == QUEUE_COUNT_WIDTH'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef ASSERT_OFF
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("queue written while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty) else $error("queue read while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_COUNT_WIDTH'(QUEUE_DEPTH)) else $error("queue count overrun");
`endif

endmodule

`default_nettype wire

[hdl/flog2_back.sv]
// squaring engine: one fraction bit per cycle, output register
// depends on flog2_pkg
`default_nettype none

module flog2_back
   import flog2_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      q_valid,
   input  wire flog2_entry_type q_entry,
   output logic           q_pop,
   output logic           rsp_valid,
   input  wire logic      rsp_ready,
   output logic signed [DATA_WIDTH-1:0]   rsp_log_result,
   output logic        [STATUS_WIDTH-1:0] rsp_status
);

   logic                    busy_ff, busy_in;
   logic [PREC_WIDTH-1:0]   count_ff, count_in;
   logic [DATA_WIDTH-1:0]   m_ff, m_in;
   logic [DATA_WIDTH-1:0]   mask_ff, mask_in;
   logic [DATA_WIDTH-1:0]   int_ff, int_in;
   logic [DATA_WIDTH-2:0]   frac_ff, frac_in;
   logic [STATUS_WIDTH-1:0] status_ff, status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]   result_ff, result_in;
   logic [STATUS_WIDTH-1:0] rsp_status_ff, rsp_status_in;

   logic [2*DATA_WIDTH-1:0] product;
   logic [DATA_WIDTH:0]     square;
   logic                    out_free;
   logic                    stepping;
   logic                    finishing;

   // mantissa kept left-aligned, so the rescale is a fixed shift and a mask
   assign product   = m_ff * m_ff;
   assign square    = product[2*DATA_WIDTH-1:DATA_WIDTH-1] & {1'b1, mask_ff};
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign stepping  = busy_ff && (count_ff != '0);
   assign finishing = busy_ff && (count_ff == '0) && out_free;
   assign q_pop     = q_valid && !busy_ff;

   always_comb begin
      busy_in       = busy_ff;
      count_in      = count_ff;
      m_in          = m_ff;
      mask_in       = mask_ff;
      int_in        = int_ff;
      frac_in       = frac_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      result_in     = result_ff;
      rsp_status_in = rsp_status_ff;
      if (q_pop) begin
         busy_in   = 1'b1;
         count_in  = q_entry.prec;
         m_in      = q_entry.mantissa;
         mask_in   = {DATA_WIDTH{1'b1}} << (5'd31 - q_entry.prec);
         int_in    = q_entry.int_part;
         frac_in   = '0;
         status_in = q_entry.status;
      end else if (stepping) begin
         count_in = count_ff - 1'b1;
         if (square[DATA_WIDTH]) begin
            m_in    = square[DATA_WIDTH:1] & mask_ff;
            frac_in = {frac_ff[DATA_WIDTH-3:0], 1'b1};
         end else begin
            m_in    = square[DATA_WIDTH-1:0];
            frac_in = {frac_ff[DATA_WIDTH-3:0], 1'b0};
         end
      end else if (finishing) begin
         busy_in       = 1'b0;
         rsp_valid_in  = 1'b1;
         result_in     = int_ff + {1'b0, frac_ff};
         rsp_status_in = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff          <= m_in;
      mask_ff       <= mask_in;
      int_ff        <= int_in;
      frac_ff       <= frac_in;
      status_ff     <= status_in;
      result_ff     <= result_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_log_result = $signed(result_ff);
   assign rsp_status     = rsp_status_ff;

`ifndef ASSERT_OFF
   a_load_count: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (count_ff == $past(q_entry.prec)))
      else $error("step count not loaded from entry");
   a_count_down: assert property (@(posedge clock) disable iff (reset)
      stepping |=> (busy_ff && count_ff == $past(count_ff) - 1'b1))
      else $error("step count did not decrement");
   a_mantissa_norm: assert property (@(posedge clock) disable iff (reset)
      stepping |-> m_ff[DATA_WIDTH-1]) else $error("mantissa lost its leading one");
   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_ZERO_INPUT) |-> (result_ff == RESULT_MIN))
      else $error("zero input result wrong");
`endif

endmodule

`default_nettype wire

[hdl/fixed_point_log2.sv]
// fixed-point base-2 logarithm, one fraction bit per squaring step
// beats pass queue, squaring steps (none on status cases), output register
// one squaring multiplier: a new beat starts only after the last one finishes
// a two-entry queue lets new beats enter while the engine or output is busy
// synchronous active-high reset clears control state, fraction_bits resets to 16
// depends on flog2_pkg, flog2_front, flog2_queue, flog2_back
`default_nettype none

module fixed_point_log2
   import flog2_pkg::*;
#(
   parameter int MAX_FRACTION_BITS = 31
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [DATA_WIDTH-1:0]         req_operand,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [DATA_WIDTH-1:0]       rsp_log_result,
   output logic        [STATUS_WIDTH-1:0]     rsp_status,
   input  wire logic                          csr_write_enable,
   input  wire logic [PREC_WIDTH-1:0]         csr_write_data
);

   logic [PREC_WIDTH-1:0] fraction_bits_ff, fraction_bits_in;
   flog2_entry_type       front_entry;
   flog2_entry_type       queue_entry;
   logic                  queue_full;
   logic                  queue_not_empty;
   logic                  queue_pop;

   assign fraction_bits_in = csr_write_enable ? csr_write_data : fraction_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fraction_bits_ff <= FRACTION_BITS_RESET;
      end else begin
         fraction_bits_ff <= fraction_bits_in;
      end
   end

   assign req_ready = !queue_full;

   flog2_front #(
      .MAX_FRACTION_BITS(MAX_FRACTION_BITS)
   ) u_front (
      .operand       (req_operand),
      .fraction_bits (fraction_bits_ff),
      .entry         (front_entry)
   );

   flog2_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid && req_ready),
      .push_entry (front_entry),
      .full       (queue_full),
      .pop        (queue_pop),
      .not_empty  (queue_not_empty),
      .pop_entry  (queue_entry)
   );

   flog2_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (queue_not_empty),
      .q_entry        (queue_entry),
      .q_pop          (queue_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_log_result (rsp_log_result),
      .rsp_status     (rsp_status)
   );

endmodule

`default_nettype wire
